### hw/rtl/quantized_row_cache_defines.svh
// ----------------------------------------------------------------------------
// Quantized row cache assertion macros
// Shared concurrent assertion helpers, one property per use.
// ----------------------------------------------------------------------------
`ifndef QUANTIZED_ROW_CACHE_DEFINES_SVH
`define QUANTIZED_ROW_CACHE_DEFINES_SVH

// same-cycle implication
`define QRC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define QRC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/qrc_pkg.sv
// ----------------------------------------------------------------------------
// Quantized row cache package
// Sizes, field widths, codes, memory port structs and helper functions.
// ----------------------------------------------------------------------------
package qrc_pkg;

   // storage geometry
   localparam int ROWS     = 256;
   localparam int MAX_COLS = 64;
   localparam int ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int CNT_W    = $clog2(ROWS + 1);
   localparam int COL_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int CP_W     = $clog2(MAX_COLS + 1);
   localparam int CELL_AW  = ROW_W + COL_W;
   localparam int CELL_DEPTH = 2 ** CELL_AW;

   // fixed field widths
   localparam int REQ_TYPE_W  = 2;
   localparam int ID_W        = 31;
   localparam int DIST_W      = 17;
   localparam int LAST_W      = 1;
   localparam int STATUS_W    = 2;
   localparam int CODE_W      = 8;
   localparam int ACTIVE_W    = 9;
   localparam int NUM_COLS_W  = 7;
   localparam int ROW_LIMIT_W = 9;
   localparam int CSR_ADDR_W  = 1;
   localparam int CSR_DATA_W  = 9;

   // quantizer: floor((d*2554900 + 4999*65536) / (65536*10000)), saturated
   localparam int Q_MUL_W  = 22;
   localparam int PROD_W   = DIST_W + Q_MUL_W;
   localparam int Q_SHIFT  = 16;
   localparam int M_W      = PROD_W - Q_SHIFT;
   localparam int MS_W     = 22;
   localparam int RECIP_W  = 19;
   localparam int Q_RSH    = 32;
   localparam int EP_W     = MS_W + RECIP_W;
   localparam int EST_W    = EP_W - Q_RSH;
   localparam logic [PROD_W-1:0]  Q_MUL   = PROD_W'(2554900);
   localparam logic [PROD_W-1:0]  Q_ADD   = PROD_W'(327614464);
   localparam logic [M_W-1:0]     Q_SAT   = M_W'(2560000);
   localparam logic [M_W-1:0]     Q_DEN   = M_W'(10000);
   localparam logic [RECIP_W-1:0] Q_RECIP = RECIP_W'(429496);
   localparam logic [CODE_W-1:0]  CODE_MAX = '1;

   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_STORE    = 2'd0,
      REQ_RETRIEVE = 2'd1,
      REQ_LOOKUP   = 2'd2,
      REQ_CLEAR    = 2'd3
   } req_code_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK   = 2'd0,
      STAT_FULL = 2'd1,
      STAT_MISS = 2'd2
   } status_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_NUM_COLS  = 1'b0,
      CSR_ROW_LIMIT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [CP_W-1:0] len;
      logic [ID_W-1:0] key;
   } tag_entry_type;

   typedef struct packed {
      logic            en;
      logic [ROW_W-1:0] addr;
      tag_entry_type   entry;
   } tag_wr_type;

   typedef struct packed {
      logic               en;
      logic [CELL_AW-1:0] addr;
      logic [CODE_W-1:0]  data;
   } cell_wr_type;

   // usable rows: min(row_limit, ROWS)
   function automatic logic [CNT_W-1:0] rows_eff_f(input logic [ROW_LIMIT_W-1:0] lim);
      if (32'(lim) >= 32'(ROWS)) return CNT_W'(ROWS);
      else return CNT_W'(lim);
   endfunction

   // columns per row, clamped to 1..MAX_COLS
   function automatic logic [CP_W-1:0] cols_eff_f(input logic [NUM_COLS_W-1:0] nc);
      if (nc == '0) return CP_W'(1);
      else if (32'(nc) > 32'(MAX_COLS)) return CP_W'(MAX_COLS);
      else return CP_W'(nc);
   endfunction

endpackage

### hw/rtl/qrc_ifs.sv
// ----------------------------------------------------------------------------
// Quantized row cache channels
// Valid/ready interfaces for requests, results and register writes.
// ----------------------------------------------------------------------------
interface qrc_req_if;
   logic                             valid;
   logic                             ready;
   logic [qrc_pkg::REQ_TYPE_W-1:0]   req_type;
   logic [qrc_pkg::ID_W-1:0]         entry_id;
   logic [qrc_pkg::DIST_W-1:0]       distance;
   logic [qrc_pkg::LAST_W-1:0]       last_col;

   modport source (output valid, req_type, entry_id, distance, last_col, input ready);
   modport sink   (input valid, req_type, entry_id, distance, last_col, output ready);
endinterface

interface qrc_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [qrc_pkg::STATUS_W-1:0]     status;
   logic                             hit;
   logic [qrc_pkg::CODE_W-1:0]       value_code;
   logic                             last_out;
   logic [qrc_pkg::ACTIVE_W-1:0]     active_rows;

   modport source (output valid, status, hit, value_code, last_out, active_rows,
                   input ready);
   modport sink   (input valid, status, hit, value_code, last_out, active_rows,
                   output ready);
endinterface

interface qrc_csr_if;
   logic                             valid;
   logic                             ready;
   logic [qrc_pkg::CSR_ADDR_W-1:0]   addr;
   logic [qrc_pkg::CSR_DATA_W-1:0]   wdata;

   modport source (output valid, addr, wdata, input ready);
   modport sink   (input valid, addr, wdata, output ready);
endinterface

### hw/rtl/quantized_row_cache.sv
// ----------------------------------------------------------------------------
// Quantized row cache
// Append-only store of quantized distance rows, looked up by a 31-bit id.
// ----------------------------------------------------------------------------
// channel    dir  handshake       payload
// req_chan   in   valid/ready     req_type, entry_id, distance, last_col
// rsp_chan   out  valid/ready     status, hit, value_code, last_out, active_rows
// csr_chan   in   valid/ready     addr, wdata
//
// Store element: the three-stage quantizer runs ahead of the cell memory
// write; a last element then loads its result through ST_EMIT.
// Retrieve/lookup: the tag scan walks rows from 0, one tag memory read per cycle;
// retrieve then reads each byte in ST_ROW_RD and gives it out in ST_ROW_OUT.
// Reset clears the fill count but not the memories: rows at or above it read
// as empty, so there is no clearing pass. A held result sits in the output
// register while the next request is taken.
// ----------------------------------------------------------------------------
`include "quantized_row_cache_defines.svh"

module quantized_row_cache (
   input  logic       clock,
   input  logic       reset,
   qrc_req_if.sink    req_chan,
   qrc_rsp_if.source  rsp_chan,
   qrc_csr_if.sink    csr_chan
);

   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_QWAIT   = 6'b000010,
      ST_SCAN    = 6'b000100,
      ST_ROW_RD  = 6'b001000,
      ST_ROW_OUT = 6'b010000,
      ST_EMIT    = 6'b100000
   } state_type;

   state_type                           state_ff, state_in;
   logic [qrc_pkg::NUM_COLS_W-1:0]      num_cols_ff, num_cols_in;
   logic [qrc_pkg::ROW_LIMIT_W-1:0]     row_limit_ff, row_limit_in;
   logic [qrc_pkg::CNT_W-1:0]           fill_count_ff, fill_count_in;
   logic [qrc_pkg::CP_W-1:0]            cp_ff, cp_in;
   logic [qrc_pkg::ID_W-1:0]            id_ff, id_in;
   logic                                last_ff, last_in;
   qrc_pkg::req_code_type               op_ff, op_in;
   logic [qrc_pkg::CNT_W-1:0]           scan_ptr_ff, scan_ptr_in;
   logic                                pend_ff, pend_in;
   logic [qrc_pkg::CNT_W-1:0]           pend_idx_ff, pend_idx_in;
   logic [qrc_pkg::ROW_W-1:0]           row_ff, row_in;
   logic [qrc_pkg::CP_W-1:0]            len_ff, len_in;
   logic [qrc_pkg::CP_W-1:0]            col_ff, col_in;
   qrc_pkg::status_type                 emit_st_ff, emit_st_in;
   logic                                emit_hit_ff, emit_hit_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   qrc_pkg::status_type                 rsp_status_ff, rsp_status_in;
   logic                                rsp_hit_ff, rsp_hit_in;
   logic [qrc_pkg::CODE_W-1:0]          rsp_code_ff, rsp_code_in;
   logic                                rsp_last_ff, rsp_last_in;
   logic [qrc_pkg::ACTIVE_W-1:0]        rsp_active_ff, rsp_active_in;

   logic                                req_acc, csr_acc, out_free;
   qrc_pkg::req_code_type               req_code;
   logic [qrc_pkg::CP_W-1:0]            cols_eff;
   logic [qrc_pkg::CNT_W-1:0]           rows_eff;
   logic                                usable;
   logic                                q_start, q_valid;
   logic [qrc_pkg::CODE_W-1:0]          q_code;
   qrc_pkg::tag_wr_type                 tag_wr;
   logic                                tag_rd_en;
   logic [qrc_pkg::ROW_W-1:0]           tag_rd_addr;
   qrc_pkg::tag_entry_type              tag_rd_data;
   qrc_pkg::cell_wr_type                cell_wr;
   logic                                cell_rd_en;
   logic [qrc_pkg::CELL_AW-1:0]         cell_rd_addr;
   logic [qrc_pkg::CODE_W-1:0]          cell_rd_data;
   logic                                scan_issue, scan_hit, scan_miss;
   logic                                commit;
   logic                                col_live, col_last;
   logic [qrc_pkg::CP_W-1:0]            cp_step;
   logic                                load;
   qrc_pkg::status_type                 load_status;
   logic                                load_hit, load_last;
   logic [qrc_pkg::CODE_W-1:0]          load_code;

   // handshakes; register writes only while idle and no request pending
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = (state_ff == ST_IDLE) && !req_chan.valid;
   assign req_acc  = req_chan.valid && req_chan.ready;
   assign csr_acc  = csr_chan.valid && csr_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_code = qrc_pkg::req_code_type'(req_chan.req_type);

   assign cols_eff = qrc_pkg::cols_eff_f(num_cols_ff);
   assign rows_eff = qrc_pkg::rows_eff_f(row_limit_ff);
   assign usable   = (fill_count_ff < rows_eff);
   assign q_start  = req_acc && (req_code == qrc_pkg::REQ_STORE);
   assign cp_step  = (cp_ff < qrc_pkg::CP_W'(qrc_pkg::MAX_COLS)) ?
                     qrc_pkg::CP_W'(cp_ff + qrc_pkg::CP_W'(1)) : cp_ff;

   // tag scan, one read issued per cycle, compared in the next cycle
   assign scan_issue = (state_ff == ST_SCAN) && (scan_ptr_ff < fill_count_ff);
   assign scan_hit   = (state_ff == ST_SCAN) && pend_ff && (tag_rd_data.key == id_ff);
   assign scan_miss  = (state_ff == ST_SCAN) && pend_ff && !scan_hit &&
                       (pend_idx_ff == qrc_pkg::CNT_W'(fill_count_ff - qrc_pkg::CNT_W'(1)));

   // row readout; columns past the stored length read as zero
   assign col_live = (col_ff < len_ff);
   assign col_last = (qrc_pkg::CP_W'(col_ff + qrc_pkg::CP_W'(1)) == cols_eff);

   qrc_quant u_quant (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_start),
      .in_dist   (req_chan.distance),
      .out_valid (q_valid),
      .out_code  (q_code)
   );

   qrc_tag_mem u_tag_mem (
      .clock   (clock),
      .wr      (tag_wr),
      .rd_en   (tag_rd_en),
      .rd_addr (tag_rd_addr),
      .rd_data (tag_rd_data)
   );

   qrc_cell_mem u_cell_mem (
      .clock   (clock),
      .wr      (cell_wr),
      .rd_en   (cell_rd_en),
      .rd_addr (cell_rd_addr),
      .rd_data (cell_rd_data)
   );

   // sequencer
   always_comb begin
      state_in      = state_ff;
      num_cols_in   = num_cols_ff;
      row_limit_in  = row_limit_ff;
      fill_count_in = fill_count_ff;
      cp_in         = cp_ff;
      id_in         = id_ff;
      last_in       = last_ff;
      op_in         = op_ff;
      scan_ptr_in   = scan_ptr_ff;
      pend_in       = 1'b0;
      pend_idx_in   = pend_idx_ff;
      row_in        = row_ff;
      len_in        = len_ff;
      col_in        = col_ff;
      emit_st_in    = emit_st_ff;
      emit_hit_in   = emit_hit_ff;
      commit        = 1'b0;
      tag_wr        = '0;
      tag_rd_en     = 1'b0;
      tag_rd_addr   = scan_ptr_ff[qrc_pkg::ROW_W-1:0];
      cell_wr       = '0;
      cell_rd_en    = 1'b0;
      cell_rd_addr  = {row_ff, col_ff[qrc_pkg::COL_W-1:0]};
      load          = 1'b0;
      load_status   = qrc_pkg::STAT_OK;
      load_hit      = 1'b0;
      load_code     = '0;
      load_last     = 1'b1;

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               id_in   = req_chan.entry_id;
               last_in = req_chan.last_col[0];
               op_in   = req_code;
               case (req_code)
                  qrc_pkg::REQ_STORE: begin
                     state_in = ST_QWAIT;
                  end
                  qrc_pkg::REQ_RETRIEVE, qrc_pkg::REQ_LOOKUP: begin
                     if (fill_count_ff == '0) begin
                        emit_st_in  = qrc_pkg::STAT_MISS;
                        emit_hit_in = 1'b0;
                        state_in    = ST_EMIT;
                     end else begin
                        scan_ptr_in = '0;
                        state_in    = ST_SCAN;
                     end
                  end
                  qrc_pkg::REQ_CLEAR: begin
                     fill_count_in = '0;
                     cp_in         = '0;
                     emit_st_in    = qrc_pkg::STAT_OK;
                     emit_hit_in   = 1'b0;
                     state_in      = ST_EMIT;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end else if (csr_acc) begin
               case (qrc_pkg::csr_index_type'(csr_chan.addr))
                  qrc_pkg::CSR_NUM_COLS:  num_cols_in  = csr_chan.wdata[qrc_pkg::NUM_COLS_W-1:0];
                  qrc_pkg::CSR_ROW_LIMIT: row_limit_in = csr_chan.wdata[qrc_pkg::ROW_LIMIT_W-1:0];
                  default: begin
                     num_cols_in = num_cols_ff;
                  end
               endcase
               fill_count_in = '0;
               cp_in         = '0;
            end
         end

         ST_QWAIT: begin
            if (q_valid) begin
               cell_wr.en   = usable && (cp_ff < cols_eff);
               cell_wr.addr = {fill_count_ff[qrc_pkg::ROW_W-1:0], cp_ff[qrc_pkg::COL_W-1:0]};
               cell_wr.data = q_code;
               if (last_ff) begin
                  commit          = usable;
                  tag_wr.en       = usable;
                  tag_wr.addr     = fill_count_ff[qrc_pkg::ROW_W-1:0];
                  tag_wr.entry    = '{len: cp_step, key: id_ff};
                  if (usable) begin
                     fill_count_in = qrc_pkg::CNT_W'(fill_count_ff + qrc_pkg::CNT_W'(1));
                  end
                  cp_in       = '0;
                  emit_st_in  = usable ? qrc_pkg::STAT_OK : qrc_pkg::STAT_FULL;
                  emit_hit_in = 1'b0;
                  state_in    = ST_EMIT;
               end else begin
                  cp_in    = cp_step;
                  state_in = ST_IDLE;
               end
            end
         end

         ST_SCAN: begin
            tag_rd_en = scan_issue;
            if (scan_issue) begin
               scan_ptr_in = qrc_pkg::CNT_W'(scan_ptr_ff + qrc_pkg::CNT_W'(1));
            end
            pend_in     = scan_issue;
            pend_idx_in = scan_ptr_ff;
            if (scan_hit) begin
               pend_in = 1'b0;
               row_in  = pend_idx_ff[qrc_pkg::ROW_W-1:0];
               len_in  = tag_rd_data.len;
               col_in  = '0;
               if (op_ff == qrc_pkg::REQ_RETRIEVE) begin
                  state_in = ST_ROW_RD;
               end else begin
                  emit_st_in  = qrc_pkg::STAT_OK;
                  emit_hit_in = 1'b1;
                  state_in    = ST_EMIT;
               end
            end else if (scan_miss) begin
               pend_in     = 1'b0;
               emit_st_in  = qrc_pkg::STAT_MISS;
               emit_hit_in = 1'b0;
               state_in    = ST_EMIT;
            end
         end

         ST_ROW_RD: begin
            cell_rd_en = col_live;
            state_in   = ST_ROW_OUT;
         end

         ST_ROW_OUT: begin
            if (out_free) begin
               load        = 1'b1;
               load_status = qrc_pkg::STAT_OK;
               load_hit    = 1'b1;
               load_code   = col_live ? cell_rd_data : '0;
               load_last   = col_last;
               if (col_last) begin
                  state_in = ST_IDLE;
               end else begin
                  col_in   = qrc_pkg::CP_W'(col_ff + qrc_pkg::CP_W'(1));
                  state_in = ST_ROW_RD;
               end
            end
         end

         ST_EMIT: begin
            if (out_free) begin
               load        = 1'b1;
               load_status = emit_st_ff;
               load_hit    = emit_hit_ff;
               state_in    = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register
   assign rsp_valid_in  = load ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);
   assign rsp_status_in = load ? load_status : rsp_status_ff;
   assign rsp_hit_in    = load ? load_hit : rsp_hit_ff;
   assign rsp_code_in   = load ? load_code : rsp_code_ff;
   assign rsp_last_in   = load ? load_last : rsp_last_ff;
   assign rsp_active_in = load ? qrc_pkg::ACTIVE_W'(fill_count_ff) : rsp_active_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         num_cols_ff   <= qrc_pkg::NUM_COLS_W'(qrc_pkg::MAX_COLS);
         row_limit_ff  <= qrc_pkg::ROW_LIMIT_W'(256);
         fill_count_ff <= '0;
         cp_ff         <= '0;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         num_cols_ff   <= num_cols_in;
         row_limit_ff  <= row_limit_in;
         fill_count_ff <= fill_count_in;
         cp_ff         <= cp_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      id_ff         <= id_in;
      last_ff       <= last_in;
      op_ff         <= op_in;
      scan_ptr_ff   <= scan_ptr_in;
      pend_idx_ff   <= pend_idx_in;
      row_ff        <= row_in;
      len_ff        <= len_in;
      col_ff        <= col_in;
      emit_st_ff    <= emit_st_in;
      emit_hit_ff   <= emit_hit_in;
      rsp_status_ff <= rsp_status_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_code_ff   <= rsp_code_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_active_ff <= rsp_active_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.hit         = rsp_hit_ff;
   assign rsp_chan.value_code  = rsp_code_ff;
   assign rsp_chan.last_out    = rsp_last_ff;
   assign rsp_chan.active_rows = rsp_active_ff;

   // checks
   `QRC_ASSERT_NOW(a_fill_bound, clock, reset, 1'b1, fill_count_ff <= rows_eff, "fill count above usable rows")
   `QRC_ASSERT_NOW(a_match_in_range, clock, reset, scan_hit, pend_idx_ff < fill_count_ff, "tag match outside filled rows")
   `QRC_ASSERT_NEXT(a_commit_count, clock, reset, commit, fill_count_ff == $past(fill_count_ff) + 1'b1, "commit did not advance fill count")

endmodule

### hw/rtl/qrc_quant.sv
// ----------------------------------------------------------------------------
// Quantized row cache distance quantizer
// Three-stage pipeline turning a Q1.16 distance into a saturated byte.
// ----------------------------------------------------------------------------
module qrc_quant (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [qrc_pkg::DIST_W-1:0]    in_dist,
   output logic                          out_valid,
   output logic [qrc_pkg::CODE_W-1:0]    out_code
);

   logic                            v1_ff, v2_ff, v3_ff;
   logic [qrc_pkg::PROD_W-1:0]      s1_prod_ff, s1_prod_in;
   logic [qrc_pkg::MS_W-1:0]        s2_m_ff, s2_m_in;
   logic                            s2_sat_ff, s2_sat_in;
   logic [qrc_pkg::EST_W-1:0]       s2_est_ff, s2_est_in;
   logic [qrc_pkg::CODE_W-1:0]      code_ff, code_in;

   logic [qrc_pkg::PROD_W-1:0]      sum;
   logic [qrc_pkg::M_W-1:0]         m_full;
   logic [qrc_pkg::EP_W-1:0]        est_prod;
   logic [qrc_pkg::M_W-1:0]         back;
   logic [qrc_pkg::M_W-1:0]         rem;
   logic [qrc_pkg::EST_W-1:0]       est_fix;

   // stage 1: scale by 255.49 in fixed point
   assign s1_prod_in = qrc_pkg::PROD_W'(in_dist) * qrc_pkg::Q_MUL;

   // stage 2: add rounding bias, drop 16 bits, estimate quotient by 10000
   assign sum       = s1_prod_ff + qrc_pkg::Q_ADD;
   assign m_full    = sum[qrc_pkg::PROD_W-1:qrc_pkg::Q_SHIFT];
   assign s2_sat_in = (m_full >= qrc_pkg::Q_SAT);
   assign s2_m_in   = m_full[qrc_pkg::MS_W-1:0];
   assign est_prod  = qrc_pkg::EP_W'(s2_m_in) * qrc_pkg::EP_W'(qrc_pkg::Q_RECIP);
   assign s2_est_in = est_prod[qrc_pkg::EP_W-1:qrc_pkg::Q_RSH];

   // stage 3: estimate may be one short, correct with the remainder
   assign back    = qrc_pkg::M_W'(s2_est_ff) * qrc_pkg::Q_DEN;
   assign rem     = qrc_pkg::M_W'(s2_m_ff) - back;
   assign est_fix = s2_est_ff + qrc_pkg::EST_W'(rem >= qrc_pkg::Q_DEN);
   assign code_in = s2_sat_ff ? qrc_pkg::CODE_MAX : est_fix[qrc_pkg::CODE_W-1:0];

   // valid pipe
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // data pipe
   always_ff @(posedge clock) begin
      s1_prod_ff <= s1_prod_in;
      s2_m_ff    <= s2_m_in;
      s2_sat_ff  <= s2_sat_in;
      s2_est_ff  <= s2_est_in;
      code_ff    <= code_in;
   end

   assign out_valid = v3_ff;
   assign out_code  = code_ff;

endmodule

### hw/rtl/qrc_tag_mem.sv
// ----------------------------------------------------------------------------
// Quantized row cache tag memory
// One entry per row: key and stored length; registered read.
// ----------------------------------------------------------------------------
module qrc_tag_mem (
   input  logic                          clock,
   input  qrc_pkg::tag_wr_type           wr,
   input  logic                          rd_en,
   input  logic [qrc_pkg::ROW_W-1:0]     rd_addr,
   output qrc_pkg::tag_entry_type        rd_data
);

   qrc_pkg::tag_entry_type mem [qrc_pkg::ROWS];
   qrc_pkg::tag_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/qrc_cell_mem.sv
// ----------------------------------------------------------------------------
// Quantized row cache cell memory
// Quantized bytes addressed by row and column; registered read.
// ----------------------------------------------------------------------------
module qrc_cell_mem (
   input  logic                          clock,
   input  qrc_pkg::cell_wr_type          wr,
   input  logic                          rd_en,
   input  logic [qrc_pkg::CELL_AW-1:0]   rd_addr,
   output logic [qrc_pkg::CODE_W-1:0]    rd_data
);

   logic [qrc_pkg::CODE_W-1:0] mem [qrc_pkg::CELL_DEPTH];
   logic [qrc_pkg::CODE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### dv/qrc_scoreboard.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Quantized row cache scoreboard
// Watches the request, result and register channels, keeps its own copy of
// the row store and checks every result against the predicted one, in order.
// ----------------------------------------------------------------------------
module qrc_scoreboard (
   input  logic clock,
   input  logic reset,
   qrc_req_if   req_mon,
   qrc_rsp_if   rsp_mon,
   qrc_csr_if   csr_mon,
   output int   fail_count,
   output int   answers_due,
   output int   answers_seen
);

   typedef struct {
      qrc_pkg::status_type                status;
      logic                               hit;
      logic [qrc_pkg::CODE_W-1:0]         code;
      logic                               last;
      logic [qrc_pkg::ACTIVE_W-1:0]       active;
   } answer_type;

   // predicted cache contents and settings
   logic [qrc_pkg::NUM_COLS_W-1:0]  num_cols_q;
   logic [qrc_pkg::ROW_LIMIT_W-1:0] row_limit_q;
   logic [qrc_pkg::ID_W-1:0]        key_mem  [qrc_pkg::ROWS];
   logic                            live_mem [qrc_pkg::ROWS];
   logic [qrc_pkg::CODE_W-1:0]      byte_mem [qrc_pkg::ROWS][qrc_pkg::MAX_COLS];
   int                              fill_rows;
   int                              col_ptr;
   answer_type                      answer_q [$];

   function automatic logic [qrc_pkg::CODE_W-1:0] quantise_distance(
      logic [qrc_pkg::DIST_W-1:0] d);
      longint unsigned dl;
      longint unsigned scaled;
      dl     = 64'(d);
      scaled = (dl * 64'd2554900 + 64'd4999 * 64'd65536) / 64'd655360000;
      return (scaled > 64'd255) ? qrc_pkg::CODE_MAX : qrc_pkg::CODE_W'(scaled);
   endfunction

   function automatic int usable_cols();
      if (num_cols_q == '0) return 1;
      if (int'(num_cols_q) > qrc_pkg::MAX_COLS) return qrc_pkg::MAX_COLS;
      return int'(num_cols_q);
   endfunction

   function automatic int usable_rows();
      return (int'(row_limit_q) >= qrc_pkg::ROWS) ? qrc_pkg::ROWS : int'(row_limit_q);
   endfunction

   // lowest live row holding the key, -1 if none
   function automatic int find_key(logic [qrc_pkg::ID_W-1:0] id);
      for (int r = 0; r < qrc_pkg::ROWS; r++) begin
         if (live_mem[r] && key_mem[r] == id) return r;
      end
      return -1;
   endfunction

   function void empty_cache();
      for (int r = 0; r < qrc_pkg::ROWS; r++) live_mem[r] = 1'b0;
      fill_rows = 0;
      col_ptr   = 0;
   endfunction

   function void push_answer(qrc_pkg::status_type st, logic hit,
                             logic [qrc_pkg::CODE_W-1:0] code, logic last);
      answer_type a;
      a.status = st;
      a.hit    = hit;
      a.code   = code;
      a.last   = last;
      a.active = qrc_pkg::ACTIVE_W'(fill_rows);
      answer_q.push_back(a);
   endfunction

   // work out the results one accepted request causes
   function void predict_cache_answers(qrc_pkg::req_code_type op,
                                       logic [qrc_pkg::ID_W-1:0] id,
                                       logic [qrc_pkg::DIST_W-1:0] elem_dist,
                                       logic last);
      int  cols;
      int  row;
      bit  usable;
      cols = usable_cols();
      case (op)
         qrc_pkg::REQ_STORE: begin
            usable = (fill_rows < usable_rows()) && (fill_rows < qrc_pkg::ROWS);
            if (usable && col_ptr < cols)
               byte_mem[fill_rows][col_ptr] = quantise_distance(elem_dist);
            if (col_ptr < qrc_pkg::MAX_COLS) col_ptr++;
            if (last) begin
               if (usable) begin
                  // columns the run never reached read back as zero
                  for (int c = col_ptr; c < qrc_pkg::MAX_COLS; c++)
                     byte_mem[fill_rows][c] = '0;
                  key_mem[fill_rows]  = id;
                  live_mem[fill_rows] = 1'b1;
                  fill_rows++;
               end
               col_ptr = 0;
               push_answer(usable ? qrc_pkg::STAT_OK : qrc_pkg::STAT_FULL, 1'b0, '0, 1'b1);
            end
         end
         qrc_pkg::REQ_RETRIEVE: begin
            row = find_key(id);
            if (row < 0) begin
               push_answer(qrc_pkg::STAT_MISS, 1'b0, '0, 1'b1);
            end else begin
               for (int c = 0; c < cols; c++)
                  push_answer(qrc_pkg::STAT_OK, 1'b1, byte_mem[row][c], c == cols - 1);
            end
         end
         qrc_pkg::REQ_LOOKUP: begin
            if (find_key(id) < 0) push_answer(qrc_pkg::STAT_MISS, 1'b0, '0, 1'b1);
            else push_answer(qrc_pkg::STAT_OK, 1'b1, '0, 1'b1);
         end
         default: begin
            empty_cache();
            push_answer(qrc_pkg::STAT_OK, 1'b0, '0, 1'b1);
         end
      endcase
   endfunction

   function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         fail_count++;
      end
   endfunction

   function void check_answer();
      answer_type a;
      if (answer_q.size() == 0) begin
         $error("result with nothing expected: status %0d value_code %0d",
                rsp_mon.status, rsp_mon.value_code);
         fail_count++;
      end else begin
         a = answer_q.pop_front();
         compare_field("status", 32'(a.status), 32'(rsp_mon.status));
         compare_field("hit", 32'(a.hit), 32'(rsp_mon.hit));
         compare_field("value_code", 32'(a.code), 32'(rsp_mon.value_code));
         compare_field("last_out", 32'(a.last), 32'(rsp_mon.last_out));
         compare_field("active_rows", 32'(a.active), 32'(rsp_mon.active_rows));
      end
      answers_seen++;
   endfunction

   // results first, so a request taken on the same edge cannot mask a stray one
   always @(posedge clock) begin
      if (reset) begin
         num_cols_q   = qrc_pkg::NUM_COLS_W'(qrc_pkg::MAX_COLS);
         row_limit_q  = qrc_pkg::ROW_LIMIT_W'(qrc_pkg::ROWS);
         empty_cache();
         answer_q.delete();
         fail_count   = 0;
         answers_seen = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) check_answer();
         if (csr_mon.valid && csr_mon.ready) begin
            if (qrc_pkg::csr_index_type'(csr_mon.addr) == qrc_pkg::CSR_NUM_COLS)
               num_cols_q = csr_mon.wdata[qrc_pkg::NUM_COLS_W-1:0];
            else
               row_limit_q = csr_mon.wdata[qrc_pkg::ROW_LIMIT_W-1:0];
            empty_cache();
         end
         if (req_mon.valid && req_mon.ready)
            predict_cache_answers(qrc_pkg::req_code_type'(req_mon.req_type),
                                  req_mon.entry_id, req_mon.distance,
                                  req_mon.last_col[0]);
      end
      answers_due = answer_q.size();
   end

endmodule

### dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Quantized row cache testbench
// Directed requests for the edge cases, then random store runs, retrieves,
// lookups and clears under several column and row settings, with random
// gaps on the request side and stalls on the result side.
// ----------------------------------------------------------------------------
module tb;

   localparam int CYCLE_LIMIT   = 600000;
   localparam int SETTLE_CYCLES = 16;

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   bursts_on = 1'b1;
   int   cycle_count;
   int   requests_sent;
   int   settings_written;
   int   run_cols = qrc_pkg::MAX_COLS;
   int   fail_count;
   int   answers_due;
   int   answers_seen;
   logic [qrc_pkg::ID_W-1:0] id_pool [6];

   qrc_req_if req_bus ();
   qrc_rsp_if rsp_bus ();
   qrc_csr_if csr_bus ();

   quantized_row_cache i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   qrc_scoreboard i_scoreboard (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_bus),
      .rsp_mon      (rsp_bus),
      .csr_mon      (csr_bus),
      .fail_count   (fail_count),
      .answers_due  (answers_due),
      .answers_seen (answers_seen)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  answers_due);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // result side back-pressure in random bursts
   initial begin
      int stall;
      stall = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall > 0) begin
            rsp_bus.ready = 1'b0;
            stall--;
         end else if (bursts_on && $urandom_range(0, 7) == 0) begin
            stall = $urandom_range(1, 13) - 1;
            rsp_bus.ready = 1'b0;
         end else begin
            rsp_bus.ready = 1'b1;
         end
      end
   end

   // one request; valid stays high into the next one unless a gap is drawn
   task automatic send_request(qrc_pkg::req_code_type op, logic [qrc_pkg::ID_W-1:0] id,
                               logic [qrc_pkg::DIST_W-1:0] elem_dist, logic last);
      @(negedge clock);
      if (bursts_on && $urandom_range(0, 3) == 0) begin
         req_bus.valid = 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_bus.req_type = op;
      req_bus.entry_id = id;
      req_bus.distance = elem_dist;
      req_bus.last_col = last;
      req_bus.valid    = 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      requests_sent++;
   endtask

   // drop valid, wait for every expected result, then let the pipe drain
   task automatic settle();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (answers_due != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(qrc_pkg::csr_index_type idx,
                            logic [qrc_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_bus.addr  = idx;
      csr_bus.wdata = value;
      csr_bus.valid = 1'b1;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   task automatic configure(int cols, int rows);
      settle();
      write_reg(qrc_pkg::CSR_NUM_COLS, qrc_pkg::CSR_DATA_W'(cols));
      write_reg(qrc_pkg::CSR_ROW_LIMIT, qrc_pkg::CSR_DATA_W'(rows));
      run_cols = (cols == 0) ? 1 : (cols > qrc_pkg::MAX_COLS ? qrc_pkg::MAX_COLS : cols);
      settings_written++;
   endtask

   function automatic logic [qrc_pkg::ID_W-1:0] pick_id();
      if ($urandom_range(0, 3) != 0) return id_pool[$urandom_range(0, 5)];
      return qrc_pkg::ID_W'($urandom);
   endfunction

   function automatic logic [qrc_pkg::DIST_W-1:0] pick_distance();
      int r;
      r = $urandom_range(0, 9);
      if (r < 8) return qrc_pkg::DIST_W'($urandom_range(0, 65536));
      if (r == 8) return ($urandom_range(0, 1) != 0) ? qrc_pkg::DIST_W'(65536) : '0;
      return qrc_pkg::DIST_W'($urandom_range(65537, 131071));
   endfunction

   // store run; may be probed mid-way or abandoned by a clear
   task automatic store_run(logic [qrc_pkg::ID_W-1:0] id, int len);
      for (int i = 0; i < len; i++) begin
         if (i < len - 1 && $urandom_range(0, 9) == 0)
            send_request(($urandom_range(0, 1) != 0) ? qrc_pkg::REQ_RETRIEVE :
                         qrc_pkg::REQ_LOOKUP, pick_id(), '0, 1'b0);
         if (i < len - 1 && $urandom_range(0, 19) == 0) begin
            send_request(qrc_pkg::REQ_CLEAR, pick_id(), pick_distance(), 1'b0);
            return;
         end
         send_request(qrc_pkg::REQ_STORE, id, pick_distance(), i == len - 1);
      end
   endtask

   task automatic random_phase(int target);
      int start;
      int pick;
      int len;
      start = requests_sent;
      while (requests_sent - start < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            // overlong runs only where rows are narrow, to keep the count down
            if (run_cols <= 8 && $urandom_range(0, 2) == 0)
               len = run_cols + $urandom_range(0, 2);
            else
               len = $urandom_range(1, ((run_cols < 3) ? run_cols : 3) + 1);
            store_run(pick_id(), len);
         end else if (pick < 70) begin
            send_request(qrc_pkg::REQ_RETRIEVE, pick_id(), pick_distance(),
                         1'($urandom_range(0, 1)));
         end else if (pick < 85) begin
            send_request(qrc_pkg::REQ_LOOKUP, pick_id(), pick_distance(),
                         1'($urandom_range(0, 1)));
         end else if (pick < 90) begin
            send_request(qrc_pkg::REQ_CLEAR, pick_id(), pick_distance(),
                         1'($urandom_range(0, 1)));
         end else begin
            // unstructured noise
            send_request(qrc_pkg::req_code_type'($urandom_range(0, 3)),
                         qrc_pkg::ID_W'($urandom),
                         qrc_pkg::DIST_W'($urandom_range(0, 131071)),
                         1'($urandom_range(0, 1)));
         end
      end
   endtask

   // edge cases, starting from the reset settings
   task automatic run_directed();
      send_request(qrc_pkg::REQ_LOOKUP, '0, '0, 1'b0);
      send_request(qrc_pkg::REQ_RETRIEVE, 31'h7FFF_FFFF, '0, 1'b1);
      send_request(qrc_pkg::REQ_STORE, 31'h7FFF_FFFF, '0, 1'b0);
      send_request(qrc_pkg::REQ_STORE, 31'h7FFF_FFFF, 17'd65536, 1'b1);
      send_request(qrc_pkg::REQ_RETRIEVE, 31'h7FFF_FFFF, '0, 1'b0);
      send_request(qrc_pkg::REQ_LOOKUP, 31'h7FFF_FFFF, '0, 1'b0);
      // long run: extra elements dropped, over-range distance saturates
      configure(3, 256);
      send_request(qrc_pkg::REQ_STORE, '0, 17'h1FFFF, 1'b0);
      send_request(qrc_pkg::REQ_STORE, '0, 17'd1, 1'b0);
      send_request(qrc_pkg::REQ_STORE, '0, 17'd32768, 1'b0);
      send_request(qrc_pkg::REQ_STORE, '0, 17'd200, 1'b0);
      send_request(qrc_pkg::REQ_STORE, '0, 17'd65535, 1'b1);
      send_request(qrc_pkg::REQ_RETRIEVE, '0, '0, 1'b0);
      // queries inside a run leave it alone
      send_request(qrc_pkg::REQ_STORE, 31'h2AAA_AAAA, 17'h15555, 1'b0);
      send_request(qrc_pkg::REQ_LOOKUP, '0, '0, 1'b0);
      send_request(qrc_pkg::REQ_RETRIEVE, '0, '0, 1'b0);
      send_request(qrc_pkg::REQ_STORE, 31'h2AAA_AAAA, 17'h0AAAA, 1'b1);
      send_request(qrc_pkg::REQ_RETRIEVE, 31'h2AAA_AAAA, '0, 1'b0);
      // duplicate id: the older row wins
      send_request(qrc_pkg::REQ_STORE, '0, 17'd12345, 1'b1);
      send_request(qrc_pkg::REQ_RETRIEVE, '0, '0, 1'b0);
      // clear abandons a run in progress
      send_request(qrc_pkg::REQ_STORE, 31'd5, 17'd40000, 1'b0);
      send_request(qrc_pkg::REQ_CLEAR, '0, '0, 1'b0);
      send_request(qrc_pkg::REQ_STORE, 31'd5, 17'd50000, 1'b1);
      send_request(qrc_pkg::REQ_LOOKUP, '0, '0, 1'b0);
      // table full
      configure(64, 1);
      send_request(qrc_pkg::REQ_STORE, 31'd9, 17'd100, 1'b1);
      send_request(qrc_pkg::REQ_STORE, 31'd10, 17'd100, 1'b1);
      configure(2, 0);
      send_request(qrc_pkg::REQ_STORE, 31'd11, 17'd100, 1'b1);
   endtask

   initial begin
      req_bus.valid    = 1'b0;
      req_bus.req_type = qrc_pkg::REQ_STORE;
      req_bus.entry_id = '0;
      req_bus.distance = '0;
      req_bus.last_col = '0;
      csr_bus.valid    = 1'b0;
      csr_bus.addr     = qrc_pkg::CSR_NUM_COLS;
      csr_bus.wdata    = '0;
      id_pool[0] = '0;
      id_pool[1] = 31'h7FFF_FFFF;
      for (int i = 2; i < 6; i++) id_pool[i] = qrc_pkg::ID_W'($urandom);
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      run_directed();
      configure(0, 5);
      random_phase(18);
      configure(127, 511);
      random_phase(18);
      configure(5, 2);
      random_phase(18);
      // closing stretch with no gaps or stalls
      bursts_on = 1'b0;
      configure(64, 256);
      random_phase(18);
      settle();

      $display("covered %0d requests over %0d register settings, %0d results checked",
               requests_sent, settings_written, answers_seen);
      if (fail_count == 0 && answers_due == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/qrc_pkg.sv
hw/rtl/qrc_ifs.sv
hw/rtl/qrc_quant.sv
hw/rtl/qrc_tag_mem.sv
hw/rtl/qrc_cell_mem.sv
hw/rtl/quantized_row_cache.sv
dv/qrc_scoreboard.sv
dv/tb.sv
